// ===== hdl/abm_pkg.sv =====
// Package for the allocation bitmap: beat types of the command and result ports,
// map geometry constants and action codes. No dependencies.
package abm_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS = 32;
    localparam int WORD_IDX_W = 5;
    localparam int SIZE_W = 6;
    localparam int INDEX_W = 10;
    localparam int FIRST_W = 11;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_TEST  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [INDEX_W-1:0] bit_index;
    } abm_in_t;

    typedef struct packed {
        logic               bit_value;
        logic [FIRST_W-1:0] first_clear;
    } abm_out_t;

endpackage

// ===== hdl/allocation_bitmap.sv =====
// Allocation bitmap top level: word store, per-word full and valid flags and control sequencer.
// Depends on abm_pkg.
//
// Usage: a command beat (item.action, item.bit_index) is taken at a rising edge with
// start high and busy low. Set and clear change one bit of the map; test reads it.
// Indices at or beyond size_words * 32 are not modified and test as 1.
// Each command yields one result beat: result.bit_value and result.first_clear, the
// lowest clear bit of the in-use map after the update, or size_words * 32 when full.
// The result is on the result port for exactly one cycle with done high.
// Steps: the accepting edge reads the addressed word, S_MOD writes it back, S_FIND
// reads the first non-full word for the bit search and S_OUT forms the result; busy
// is high through these states and done rises after S_OUT, so a new command is taken
// only once the last has finished. The word store has one read and one write port.
// The receiver cannot stall; a new command may be given in the cycle done is high.
// cfg_we writes cfg_wdata into size_words; write it only while busy is low.
// Reset: size_words returns to 32 and the map reads as all zeros through per-word
// valid flags, so no clearing pass is needed and start is taken right after reset.
module allocation_bitmap (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  abm_pkg::abm_in_t                  item,
    input  logic                              cfg_we,
    input  logic [abm_pkg::SIZE_W-1:0]        cfg_wdata,
    output logic                              done,
    output abm_pkg::abm_out_t                 result
);
    import abm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MOD, S_FIND, S_OUT} state_t;

    state_t                 state_reg;
    logic                   busy_reg;
    logic                   done_reg;
    abm_out_t               result_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [1:0]             act_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [MAX_WORDS-1:0]   full_reg;
    logic [MAX_WORDS-1:0]   valid_reg;
    logic                   rd_valid_reg;
    logic                   bit_reg;
    logic [WORD_IDX_W-1:0]  find_word_reg;
    logic                   find_any_reg;

    logic [WORD_BITS-1:0]   mem [MAX_WORDS];
    logic [WORD_BITS-1:0]   rd_data_reg;

    logic [SIZE_W-1:0]      eff_words;
    logic [FIRST_W-1:0]     size_bits;
    logic                   in_range;
    logic [WORD_BITS-1:0]   rd_word;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [WORD_BITS-1:0]   new_word;
    logic                   mem_we;
    logic [WORD_IDX_W-1:0]  rd_addr;
    logic [MAX_WORDS-1:0]   in_use;
    logic [MAX_WORDS-1:0]   eligible;
    logic [WORD_IDX_W-1:0]  find_word_next;
    logic                   find_any_next;
    logic [WORD_IDX_W-1:0]  zero_off;
    logic                   zero_any;
    logic                   bit_next;
    abm_out_t               result_next;
    logic                   accept;

    function automatic logic [WORD_IDX_W:0] lowest_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_IDX_W:0] res;
        res = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                res = {1'b1, WORD_IDX_W'(i)};
            end
        end
        return res;
    endfunction

    assign accept    = start && !busy_reg;
    assign eff_words = (size_reg > SIZE_W'(MAX_WORDS)) ? SIZE_W'(MAX_WORDS) : size_reg;
    assign size_bits = {eff_words, {WORD_IDX_W{1'b0}}};
    assign in_range  = {1'b0, idx_reg} < size_bits;
    assign rd_word   = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask  = WORD_BITS'(1) << idx_reg[WORD_IDX_W-1:0];

    always_comb
    begin
        new_word = rd_word;
        bit_next = 1'b0;
        unique case (act_reg)
            ACT_SET:   new_word = rd_word | bit_mask;
            ACT_CLEAR: new_word = rd_word & ~bit_mask;
            ACT_TEST:  bit_next = in_range ? rd_word[idx_reg[WORD_IDX_W-1:0]] : 1'b1;
            default:   bit_next = 1'b0;
        endcase
    end

    assign mem_we = (state_reg == S_MOD) && in_range
                    && ((act_reg == ACT_SET) || (act_reg == ACT_CLEAR));

    always_comb
    begin
        for (int i = 0; i < MAX_WORDS; i++) begin
            in_use[i] = SIZE_W'(i) < eff_words;
        end
    end

    assign eligible = ~full_reg & in_use;
    assign {find_any_next, find_word_next} = lowest_one(eligible);
    assign {zero_any, zero_off} = lowest_one(~rd_word);

    assign rd_addr = (state_reg == S_IDLE) ? item.bit_index[INDEX_W-1:WORD_IDX_W]
                                           : find_word_next;

    always_comb
    begin
        result_next.bit_value = bit_reg;
        if (find_any_reg && zero_any)
        begin
            result_next.first_clear = {1'b0, find_word_reg, zero_off};
        end
        else
        begin
            result_next.first_clear = size_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg[INDEX_W-1:WORD_IDX_W]] <= new_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            size_reg      <= SIZE_W'(MAX_WORDS);
            full_reg      <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            act_reg       <= '0;
            idx_reg       <= '0;
            bit_reg       <= 1'b0;
            find_word_reg <= '0;
            find_any_reg  <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg     <= (state_reg == S_OUT);
            rd_valid_reg <= valid_reg[rd_addr];
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg   <= item.action;
                        idx_reg   <= item.bit_index;
                        state_reg <= S_MOD;
                        busy_reg  <= 1'b1;
                    end
                end
                S_MOD:
                begin
                    bit_reg <= bit_next;
                    if (mem_we)
                    begin
                        valid_reg[idx_reg[INDEX_W-1:WORD_IDX_W]] <= 1'b1;
                        full_reg[idx_reg[INDEX_W-1:WORD_IDX_W]]  <= &new_word;
                    end
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    find_word_reg <= find_word_next;
                    find_any_reg  <= find_any_next;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    result_reg <= result_next;
                    busy_reg   <= 1'b0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat ends the command, so the block is free in that cycle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result beat while busy");

    // An accepted command yields its result beat once it has passed S_MOD, S_FIND and S_OUT.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> ##3 done_reg)
        else $error("result beat missing four cycles after the accepted command");

    // The reported position never exceeds the in-use map size in bits.
    a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.first_clear <= size_bits))
        else $error("first clear index beyond map size");

    // A test or unused action leaves the full and valid flags untouched.
    a_test_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOD) && (act_reg != ACT_SET) && (act_reg != ACT_CLEAR))
        |=> $stable(full_reg) && $stable(valid_reg))
        else $error("map flags changed by a non-writing command");

endmodule
